// ===== src/awa_pkg.sv =====
// shared constants for the anemometer wind aggregator
`default_nettype none
package awa_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_WINDOWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_OFFSET     = 3'd4;

  localparam logic [15:0] WINDOW_MS_RST      = 16'd3000;
  localparam logic [3:0]  REPORT_WINDOWS_RST = 4'd5;
  localparam logic [7:0]  MIN_PULSE_GAP_RST  = 8'd8;
  localparam logic [10:0] ADC_FULL_SCALE_RST = 11'd1648;
  localparam logic [8:0]  DIR_OFFSET_RST     = 9'd0;

  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 16;

  localparam logic [35:0] RATE_SCALE = 36'd256000;
  localparam logic [15:0] RATE_SAT   = 16'hFFFF;
  localparam logic [20:0] SUM_SAT    = 21'h0FFFFF;
  localparam logic [19:0] AVG_MIN    = 20'd256;
  localparam logic [7:0]  GAP_SAT    = 8'hFF;

  localparam logic [20:0] DEG_TURN_NUM = 21'd360;
  localparam logic [9:0]  DEG_TURN     = 10'd360;
  localparam logic [9:0]  DEG_TWO_TURN = 10'd720;
  localparam logic [9:0]  DEG_STEP     = 10'd5;

endpackage
`default_nettype wire

// ===== src/anemometer_wind_aggregator.sv =====
// top level: pulse windowing, rate average, gust and vane direction report
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_ready_o | pulse_seen_i, vane_sample_i
//  out     | output    | out_valid_o/out_ready_i | direction_deg_o, average_rate_o, gust_rate_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//
//  a tick that does not close a window leaves the block ready for the next tick
//  a window-closing tick waits on the 36-step shared divider
//  a report tick makes three passes through that divider
//  no clearing pass after reset; cfg writes are taken in any cycle
//  the result sits in an output register, so a stalled out beat only holds the
//  block when the next report is ready to load
`default_nettype none
module anemometer_wind_aggregator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              pulse_seen_i,
  input  wire logic [10:0]                       vane_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [8:0]                        direction_deg_o,
  output logic      [15:0]                       average_rate_o,
  output logic      [15:0]                       gust_rate_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [awa_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [awa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int NumW = awa_pkg::DIV_NUM_W;
  localparam int DenW = awa_pkg::DIV_DEN_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RPREP  = 4'd1;
  localparam logic [3:0] S_RWAIT  = 4'd2;
  localparam logic [3:0] S_APREP  = 4'd3;
  localparam logic [3:0] S_AWAIT  = 4'd4;
  localparam logic [3:0] S_DPREP1 = 4'd5;
  localparam logic [3:0] S_DPREP2 = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_MOD    = 4'd8;

  // configuration
  logic [15:0] win_q;
  logic [3:0]  nrep_q;
  logic [7:0]  gap_q;
  logic [10:0] fs_q;
  logic [8:0]  off_q;

  logic [15:0] win_eff;
  logic [3:0]  nrep_eff;
  logic [10:0] fs_eff;

  // running state
  logic [3:0]  state_q, state_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] pcount_q, pcount_d;
  logic [7:0]  since_q, since_d;
  logic        first_q, first_d;
  logic [3:0]  widx_q, widx_d;
  logic [19:0] sum_q, sum_d;
  logic [15:0] max_q, max_d;
  logic [10:0] vane_q, vane_d;
  logic [15:0] avg_q, avg_d;
  logic [20:0] num_q, num_d;
  logic [9:0]  deg_q, deg_d;

  logic        out_valid_q, out_valid_d;
  logic [8:0]  dir_out_q, dir_out_d;
  logic [15:0] avg_out_q, avg_out_d;
  logic [15:0] gust_out_q, gust_out_d;

  // tick update
  logic [7:0]  since_inc;
  logic        take;
  logic [15:0] elapsed_inc;

  // divider hookup
  logic            div_start;
  logic [NumW-1:0] div_num;
  logic [DenW-1:0] div_den;
  logic            div_done;
  logic [NumW-1:0] div_quot;

  logic [15:0] quot_sat;
  logic [20:0] sum_add;
  logic [3:0]  widx_inc;
  logic [3:0]  n_eff;
  logic [10:0] vane_sat;
  logic [9:0]  deg_wrapped;
  logic        out_free;

  assign win_eff  = (win_q == '0) ? 16'd1 : win_q;
  assign nrep_eff = (nrep_q == '0) ? 4'd1 : nrep_q;
  assign fs_eff   = (fs_q == '0) ? 11'd1 : fs_q;
  assign n_eff    = (widx_q == '0) ? 4'd1 : widx_q;
  assign vane_sat = (vane_q > fs_eff) ? fs_eff : vane_q;

  assign since_inc   = (since_q == awa_pkg::GAP_SAT) ? since_q : since_q + 8'd1;
  assign take        = pulse_seen_i && (first_q || (since_inc >= gap_q));
  assign elapsed_inc = elapsed_q + 16'd1;

  assign quot_sat = (div_quot > NumW'(awa_pkg::RATE_SAT)) ? awa_pkg::RATE_SAT
                                                          : div_quot[15:0];
  assign sum_add  = 21'(sum_q) + 21'(quot_sat);
  assign widx_inc = widx_q + 4'd1;

  assign deg_wrapped = (deg_q >= awa_pkg::DEG_TWO_TURN) ? deg_q - awa_pkg::DEG_TWO_TURN :
                       (deg_q >= awa_pkg::DEG_TURN)     ? deg_q - awa_pkg::DEG_TURN : deg_q;

  assign out_free = !out_valid_q || out_ready_i;

  // operand select for the shared divider
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_RPREP: begin
        div_start = 1'b1;
        div_num   = NumW'(pcount_q) * awa_pkg::RATE_SCALE + NumW'(win_eff >> 1);
        div_den   = DenW'(win_eff);
      end
      S_APREP: begin
        div_start = 1'b1;
        div_num   = NumW'(sum_q) + NumW'(n_eff >> 1);
        div_den   = DenW'(n_eff);
      end
      S_DPREP2: begin
        div_start = 1'b1;
        div_num   = NumW'({num_q, 1'b0}) + NumW'({fs_eff, 2'b00}) + NumW'(fs_eff);
        div_den   = (DenW'(fs_eff) << 3) + (DenW'(fs_eff) << 1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  awa_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    pcount_d    = pcount_q;
    since_d     = since_q;
    first_d     = first_q;
    widx_d      = widx_q;
    sum_d       = sum_q;
    max_d       = max_q;
    vane_d      = vane_q;
    avg_d       = avg_q;
    num_d       = num_q;
    deg_d       = deg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dir_out_d   = dir_out_q;
    avg_out_d   = avg_out_q;
    gust_out_d  = gust_out_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          vane_d    = vane_sample_i;
          since_d   = take ? 8'd0 : since_inc;
          first_d   = take ? 1'b0 : first_q;
          pcount_d  = (take && (pcount_q != awa_pkg::RATE_SAT)) ? pcount_q + 16'd1 : pcount_q;
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= win_eff) begin
            state_d = S_RPREP;
          end
        end
      end
      S_RPREP: begin
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_done) begin
          sum_d     = (sum_add > awa_pkg::SUM_SAT) ? awa_pkg::SUM_SAT[19:0] : sum_add[19:0];
          max_d     = (quot_sat > max_q) ? quot_sat : max_q;
          elapsed_d = '0;
          pcount_d  = '0;
          first_d   = 1'b1;
          widx_d    = widx_inc;
          state_d   = (widx_inc < nrep_eff) ? S_IDLE : S_APREP;
        end
      end
      S_APREP: begin
        state_d = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_done) begin
          avg_d   = (sum_q > awa_pkg::AVG_MIN) ? quot_sat : 16'd0;
          state_d = S_DPREP1;
        end
      end
      S_DPREP1: begin
        num_d   = 21'(vane_sat) * awa_pkg::DEG_TURN_NUM + 21'(off_q) * 21'(fs_eff);
        state_d = S_DPREP2;
      end
      S_DPREP2: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          deg_d   = 10'(div_quot[7:0]) * awa_pkg::DEG_STEP;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dir_out_d   = deg_wrapped[8:0];
          avg_out_d   = avg_q;
          gust_out_d  = max_q;
          widx_d      = '0;
          sum_d       = '0;
          max_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= awa_pkg::WINDOW_MS_RST;
      nrep_q <= awa_pkg::REPORT_WINDOWS_RST;
      gap_q  <= awa_pkg::MIN_PULSE_GAP_RST;
      fs_q   <= awa_pkg::ADC_FULL_SCALE_RST;
      off_q  <= awa_pkg::DIR_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        awa_pkg::REG_WINDOW_MS:      win_q  <= cfg_data_i[15:0];
        awa_pkg::REG_REPORT_WINDOWS: nrep_q <= cfg_data_i[3:0];
        awa_pkg::REG_MIN_PULSE_GAP:  gap_q  <= cfg_data_i[7:0];
        awa_pkg::REG_ADC_FULL_SCALE: fs_q   <= cfg_data_i[10:0];
        awa_pkg::REG_DIR_OFFSET:     off_q  <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elapsed_q   <= '0;
      pcount_q    <= '0;
      since_q     <= '0;
      first_q     <= 1'b1;
      widx_q      <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      pcount_q    <= pcount_d;
      since_q     <= since_d;
      first_q     <= first_d;
      widx_q      <= widx_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vane_q     <= vane_d;
    avg_q      <= avg_d;
    num_q      <= num_d;
    deg_q      <= deg_d;
    dir_out_q  <= dir_out_d;
    avg_out_q  <= avg_out_d;
    gust_out_q <= gust_out_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign direction_deg_o = dir_out_q;
  assign average_rate_o  = avg_out_q;
  assign gust_rate_o     = gust_out_q;

endmodule
`default_nettype wire

// ===== src/awa_div.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
`default_nettype none
module awa_div #(
  parameter int NumW = awa_pkg::DIV_NUM_W,
  parameter int DenW = awa_pkg::DIV_DEN_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quotient_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] work_q, work_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   rem_shift;
  logic [DenW:0]   rem_sub;
  logic            ge;

  always_comb begin
    rem_shift = {rem_q, work_q[NumW-1]};
    rem_sub   = rem_shift - {1'b0, den_q};
    ge        = rem_shift >= {1'b0, den_q};
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = {work_q[NumW-2:0], ge};
      rem_d  = ge ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      work_q <= work_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule
`default_nettype wire

// ===== dv/awa_wind_report_checker.sv =====
// checker for the wind aggregator: tracks settings, predicts reports, compares report beats
module awa_wind_report_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_valid_i,
  input  logic                           tick_ready_i,
  input  logic                           pulse_seen_i,
  input  logic [10:0]                    vane_sample_i,
  input  logic                           rep_valid_i,
  input  logic                           rep_ready_i,
  input  logic [8:0]                     direction_deg_i,
  input  logic [15:0]                    average_rate_i,
  input  logic [15:0]                    gust_rate_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [awa_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [awa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             mismatch_count_o,
  output int                             reports_due_o,
  output int                             reports_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0]  direction_deg;
    logic [15:0] average_rate;
    logic [15:0] gust_rate;
  } wind_report_t;

  wind_report_t reports_pending[$];

  logic [15:0] win_ms;
  logic [3:0]  n_windows;
  logic [7:0]  pulse_gap;
  logic [10:0] full_scale;
  logic [8:0]  dir_offset;

  logic [15:0] ms_in_window;
  logic [15:0] pulses;
  logic [7:0]  ms_since_pulse;
  logic        awaiting_first;
  logic [3:0]  windows_done;
  logic [19:0] rate_total;
  logic [15:0] peak_rate;

  function automatic logic [8:0] vane_to_degrees(logic [10:0] code);
    longint unsigned fs, v, num, steps;
    fs = (full_scale == 0) ? 1 : longint'(full_scale);
    v = (longint'(code) > fs) ? fs : longint'(code);
    num = v * 360 + longint'(dir_offset) * fs;
    steps = (num * 2 + 5 * fs) / (10 * fs);
    return 9'((steps * 5) % 360);
  endfunction

  task automatic apply_register(input logic [awa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [awa_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      awa_pkg::REG_WINDOW_MS:      win_ms = val[15:0];
      awa_pkg::REG_REPORT_WINDOWS: n_windows = val[3:0];
      awa_pkg::REG_MIN_PULSE_GAP:  pulse_gap = val[7:0];
      awa_pkg::REG_ADC_FULL_SCALE: full_scale = val[10:0];
      awa_pkg::REG_DIR_OFFSET:     dir_offset = val[8:0];
      default: ;
    endcase
  endtask

  task automatic advance_one_ms(input logic pulse, input logic [10:0] vane);
    longint unsigned eff_win, eff_rep, q, n, avg, total;
    logic [15:0] rate;
    wind_report_t due;
    eff_win = (win_ms == 0) ? 1 : longint'(win_ms);
    eff_rep = (n_windows == 0) ? 1 : longint'(n_windows);
    if (ms_since_pulse != awa_pkg::GAP_SAT) ms_since_pulse++;
    if (pulse && (awaiting_first || ms_since_pulse >= pulse_gap)) begin
      if (pulses != awa_pkg::RATE_SAT) pulses++;
      ms_since_pulse = '0;
      awaiting_first = 1'b0;
    end
    ms_in_window++;
    if (longint'(ms_in_window) >= eff_win) begin
      q = (longint'(pulses) * 256000 + eff_win / 2) / eff_win;
      rate = (q > 65535) ? awa_pkg::RATE_SAT : q[15:0];
      total = longint'(rate_total) + longint'(rate);
      rate_total = (total > longint'(awa_pkg::SUM_SAT)) ? awa_pkg::SUM_SAT[19:0] : total[19:0];
      if (rate > peak_rate) peak_rate = rate;
      ms_in_window = '0;
      pulses = '0;
      awaiting_first = 1'b1;
      windows_done = windows_done + 4'd1;
      if (longint'(windows_done) >= eff_rep) begin
        n = (windows_done == 0) ? 1 : longint'(windows_done);
        avg = (rate_total > awa_pkg::AVG_MIN) ? (longint'(rate_total) + n / 2) / n : 0;
        if (avg > 65535) avg = 65535;
        due.direction_deg = vane_to_degrees(vane);
        due.average_rate = avg[15:0];
        due.gust_rate = peak_rate;
        reports_pending.insert(reports_pending.size(), due);
        windows_done = '0;
        rate_total = '0;
        peak_rate = '0;
      end
    end
  endtask

  task automatic check_report();
    wind_report_t want;
    reports_seen_o++;
    if (reports_pending.size() == 0) begin
      $error("report beat with no report due: direction_deg %0d average_rate %0d gust_rate %0d",
             direction_deg_i, average_rate_i, gust_rate_i);
      mismatch_count_o++;
    end else begin
      want = reports_pending[0];
      reports_pending.delete(0);
      if (direction_deg_i !== want.direction_deg) begin
        $error("direction_deg: expected %0d, actual %0d", want.direction_deg, direction_deg_i);
        mismatch_count_o++;
      end
      if (average_rate_i !== want.average_rate) begin
        $error("average_rate: expected %0d, actual %0d", want.average_rate, average_rate_i);
        mismatch_count_o++;
      end
      if (gust_rate_i !== want.gust_rate) begin
        $error("gust_rate: expected %0d, actual %0d", want.gust_rate, gust_rate_i);
        mismatch_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ms = awa_pkg::WINDOW_MS_RST;
      n_windows = awa_pkg::REPORT_WINDOWS_RST;
      pulse_gap = awa_pkg::MIN_PULSE_GAP_RST;
      full_scale = awa_pkg::ADC_FULL_SCALE_RST;
      dir_offset = awa_pkg::DIR_OFFSET_RST;
      ms_in_window = '0;
      pulses = '0;
      ms_since_pulse = '0;
      awaiting_first = 1'b1;
      windows_done = '0;
      rate_total = '0;
      peak_rate = '0;
      reports_pending.delete();
      mismatch_count_o = 0;
      reports_due_o = 0;
      reports_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register(cfg_addr_i, cfg_data_i);
      if (tick_valid_i && tick_ready_i) advance_one_ms(pulse_seen_i, vane_sample_i);
      if (rep_valid_i && rep_ready_i) check_report();
      reports_due_o = reports_pending.size();
    end
  end

endmodule

// ===== dv/tb_anemometer_wind_aggregator.sv =====
// testbench top for the wind aggregator: tick and register stimulus, stalls, verdict
module tb_anemometer_wind_aggregator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TICK_TARGET     = 1450;
  localparam int unsigned PHASE_TICKS_MAX = 200;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           pulse_seen_i;
  logic [10:0]                    vane_sample_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [8:0]                     direction_deg_o;
  logic [15:0]                    average_rate_o;
  logic [15:0]                    gust_rate_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [awa_pkg::CFG_IDX_W-1:0]  cfg_addr_i;
  logic [awa_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int          mismatch_count;
  int          reports_due;
  int          reports_seen;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  logic        pressure_go;

  anemometer_wind_aggregator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pulse_seen_i    (pulse_seen_i),
    .vane_sample_i   (vane_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .direction_deg_o (direction_deg_o),
    .average_rate_o  (average_rate_o),
    .gust_rate_o     (gust_rate_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  awa_wind_report_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (in_valid_i),
    .tick_ready_i     (in_ready_o),
    .pulse_seen_i     (pulse_seen_i),
    .vane_sample_i    (vane_sample_i),
    .rep_valid_i      (out_valid_o),
    .rep_ready_i      (out_ready_i),
    .direction_deg_i  (direction_deg_o),
    .average_rate_i   (average_rate_o),
    .gust_rate_i      (gust_rate_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due),
    .reports_seen_o   (reports_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // report side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    logic        pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic set_idle(input int unsigned phase_sel);
    case (phase_sel)
      0: begin
        tx_idle_pct = 15;
        rx_idle_pct = 66;
      end
      1: begin
        tx_idle_pct = 66;
        rx_idle_pct = 15;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [awa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [awa_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // upper data bits beyond each register's width are noise
  task automatic program_regs(input int unsigned win, nrep, gap, fs, off);
    write_reg(awa_pkg::REG_WINDOW_MS, 16'(win));
    write_reg(awa_pkg::REG_REPORT_WINDOWS, {12'($urandom), 4'(nrep)});
    write_reg(awa_pkg::REG_MIN_PULSE_GAP, {8'($urandom), 8'(gap)});
    write_reg(awa_pkg::REG_ADC_FULL_SCALE, {5'($urandom), 11'(fs)});
    write_reg(awa_pkg::REG_DIR_OFFSET, {7'($urandom), 9'(off)});
    write_reg(awa_pkg::CFG_IDX_W'(awa_pkg::REG_DIR_OFFSET + $urandom_range(1, 3)),
              16'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_ms(input logic pulse, input logic [10:0] vane);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pulse_seen_i <= pulse;
    vane_sample_i <= vane;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reports_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase();
    int unsigned win, nrep, gap, fs, off, density, span, count;
    logic [10:0] vane;
    win = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
    nrep = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
    case ($urandom_range(5))
      0:       gap = 0;
      1:       gap = 255;
      default: gap = $urandom_range(0, 6);
    endcase
    case ($urandom_range(5))
      0:       fs = 0;
      1:       fs = 1;
      2:       fs = 2047;
      default: fs = $urandom_range(1, 2047);
    endcase
    case ($urandom_range(4))
      0:       off = 0;
      1:       off = 511;
      2:       off = 359;
      default: off = $urandom_range(0, 511);
    endcase
    density = $urandom_range(0, 100);
    program_regs(win, nrep, gap, fs, off);
    span = ((win == 0) ? 1 : win) * ((nrep == 0) ? 1 : nrep);
    count = span * $urandom_range(1, 3) + $urandom_range(0, span);
    if (count > PHASE_TICKS_MAX) count = PHASE_TICKS_MAX;
    repeat (count) begin
      case ($urandom_range(7))
        0:       vane = 11'h7FF;
        1:       vane = 11'h000;
        default: vane = 11'($urandom_range(0, 2047));
      endcase
      send_ms($urandom_range(99) < density, vane);
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pulse_seen_i = 1'b0;
    vane_sample_i = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    pressure_go = 1'b0;
    quiet_cycles = 0;
    ticks_sent = 0;
    settings_used = 0;
    set_idle(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gap, full scale and offset; vane above full scale
    write_reg(awa_pkg::REG_WINDOW_MS, 16'd10);
    write_reg(awa_pkg::REG_REPORT_WINDOWS, 16'd1);
    cfg_valid_i <= 1'b0;
    settings_used++;
    for (int i = 0; i < 10; i++) send_ms(1'b1, (i == 9) ? 11'h7FF : 11'h000);
    settle();

    // zero window, report count and full scale act as one; offset past a turn
    program_regs(0, 0, 0, 0, 511);
    send_ms(1'b0, 11'h000);
    send_ms(1'b1, 11'h001);
    send_ms(1'b0, 11'h7FF);
    send_ms(1'b1, 11'h400);
    settle();

    // only the first pulse of each window counts with the widest gap
    program_regs(4, 2, 255, 2047, 0);
    for (int i = 0; i < 8; i++) send_ms(1'b1, (i == 7) ? 11'd1023 : 11'h7FF);
    settle();
    program_regs(4, 1, 0, 2047, 180);
    for (int i = 0; i < 4; i++) send_ms(1'b1, 11'd1024);
    settle();

    // long window: a lone pulse gives a sum of exactly AVG_MIN, so the average reads zero
    program_regs(1000, 1, 0, awa_pkg::ADC_FULL_SCALE_RST, 0);
    for (int i = 0; i < 1000; i++) begin
      send_ms(i == 499, 11'($urandom_range(0, 2047)));
    end
    settle();

    // every tick reports while the report side holds off
    program_regs(1, 1, $urandom_range(0, 255), $urandom_range(1, 2047), $urandom_range(0, 359));
    pressure_go <= 1'b1;
    for (int i = 0; i < 40; i++) send_ms($urandom_range(1), 11'($urandom_range(0, 2047)));
    settle();

    while (ticks_sent < TICK_TARGET) begin
      set_idle((ticks_sent < 1250) ? 1 : 2);
      run_random_phase();
    end

    $display("covered %0d ms ticks under %0d register settings", ticks_sent, settings_used);
    $display("checked %0d reports, including a long report-side hold-off", reports_seen);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
